@@ rtl/trs_pkg.sv @@
// trs_pkg: shared types, constants and codes of the trajectory distance resampler
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    // run limit and counter width
    localparam int unsigned MAX_RUN = 64;
    localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);

    // iterative divider width
    localparam int unsigned DIV_W   = 48;
    localparam int unsigned DIV_CW  = $clog2(DIV_W);

    // register indexes
    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_MAX_STEP = 1'b1;

    // register reset values
    localparam logic [30:0] INTERVAL_RST = 31'd65536;
    localparam logic [30:0] MAX_STEP_RST = 31'd655360;

    // result kinds
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_GAP    = 2'd1;
    localparam logic [1:0] KIND_INTERP = 2'd2;

    // input word
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [62:0]        time_ns;
    } in_item_t;

    // result word
    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [62:0]        out_time_ns;
        logic [31:0]        sample_id;
        logic [1:0]         kind;
        logic [16:0]        ratio;
        logic               last;
        logic               overflow;
    } out_item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [30:0] interval;
        logic [30:0] max_step;
    } cfg_t;

    // classified pose handed from front to back
    typedef struct packed {
        logic        first;
        logic        huge;
        logic [31:0] prev_x;
        logic [31:0] prev_y;
        logic [31:0] prev_z;
        logic [62:0] prev_t;
        logic [31:0] cur_x;
        logic [31:0] cur_y;
        logic [31:0] cur_z;
        logic [62:0] cur_t;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [62:0] dt;
        logic        t_neg;
    } job_t;

    // back end sequencer states
    typedef enum logic [4:0] {
        B_IDLE,
        B_SQ_X,
        B_SQ_Y,
        B_SQ_Z,
        B_SQ_END,
        B_SQRT,
        B_ROUND,
        B_CHECK,
        B_DUE,
        B_RATIO,
        B_RATIO_WAIT,
        B_MX,
        B_MY,
        B_MZ,
        B_MTH,
        B_MTL,
        B_MTF,
        B_FORM,
        B_EMIT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/trs_front.sv @@
// trs_front: accepts poses, keeps the previous pose and classifies each step
// depends on trs_pkg
`timescale 1ns / 1ps
`default_nettype none

module trs_front
    import trs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    input  wire logic     q_full,
    output logic          q_push,
    output job_t          q_job
);

    logic [31:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [62:0] prev_t_reg;
    logic        have_prev_reg;
    logic signed [32:0] dx, dy, dz;
    logic [32:0] ax, ay, az;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // coordinate differences and magnitudes
    always_comb
    begin
        dx = {in_data.pos_x[31], in_data.pos_x} - {prev_x_reg[31], prev_x_reg};
        dy = {in_data.pos_y[31], in_data.pos_y} - {prev_y_reg[31], prev_y_reg};
        dz = {in_data.pos_z[31], in_data.pos_z} - {prev_z_reg[31], prev_z_reg};
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        az = dz[32] ? 33'(-dz) : 33'(dz);
    end

    // job word
    always_comb
    begin
        q_job.first  = !have_prev_reg;
        q_job.huge   = ax[32] | ax[31] | ay[32] | ay[31] | az[32] | az[31];
        q_job.prev_x = prev_x_reg;
        q_job.prev_y = prev_y_reg;
        q_job.prev_z = prev_z_reg;
        q_job.prev_t = prev_t_reg;
        q_job.cur_x  = in_data.pos_x;
        q_job.cur_y  = in_data.pos_y;
        q_job.cur_z  = in_data.pos_z;
        q_job.cur_t  = in_data.time_ns;
        q_job.mag_x  = ax[31:0];
        q_job.mag_y  = ay[31:0];
        q_job.mag_z  = az[31:0];
        q_job.neg_x  = dx[32];
        q_job.neg_y  = dy[32];
        q_job.neg_z  = dz[32];
        q_job.t_neg  = in_data.time_ns < prev_t_reg;
        q_job.dt     = q_job.t_neg ? (prev_t_reg - in_data.time_ns)
                                   : (in_data.time_ns - prev_t_reg);
    end

    // previous pose, replaced by every word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            prev_t_reg    <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (q_push)
        begin
            prev_x_reg    <= in_data.pos_x;
            prev_y_reg    <= in_data.pos_y;
            prev_z_reg    <= in_data.pos_z;
            prev_t_reg    <= in_data.time_ns;
            have_prev_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/trs_queue.sv @@
// trs_queue: two-entry queue of classified poses between front and back
// depends on trs_pkg
`timescale 1ns / 1ps
`default_nettype none

module trs_queue
    import trs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/trs_div.sv @@
// trs_div: restoring divider, one quotient bit per cycle
// depends on trs_pkg
`timescale 1ns / 1ps
`default_nettype none

module trs_div
    import trs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [31:0]      divisor,
    output logic                  done,
    output logic [DIV_W-1:0]      quot,
    output logic [31:0]           rem
);

    logic [DIV_W-1:0]  quot_reg;
    logic [31:0]       rem_reg, div_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [32:0]       shifted, diff;
    logic              qbit;

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quot_reg[DIV_W-1]};
        diff    = shifted - {1'b0, div_reg};
        qbit    = !diff[32];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_W-2:0], qbit};
            rem_reg  <= qbit ? diff[31:0] : shifted[31:0];
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/trs_back.sv @@
// trs_back: step length, accumulator, interpolation and output register
// depends on trs_pkg and trs_div
`timescale 1ns / 1ps
`default_nettype none

module trs_back
    import trs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_not_empty,
    input  wire job_t q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [63:0] prod_reg, sum_reg, sum_next;
    logic [63:0] srem_reg, srem_next, root_reg, root_next;
    logic [4:0]  scnt_reg, scnt_next;
    logic [32:0] step_reg, step_next;
    logic [32:0] acc_reg, acc_next;
    logic [32:0] run_acc_reg, run_acc_next;
    logic [RUN_W-1:0] run_total_reg, run_total_next, run_k_reg, run_k_next;
    logic        run_ovf_reg, run_ovf_next;
    logic [16:0] ratio_reg, ratio_next;
    logic [48:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next, tl_reg, tl_next;
    logic [31:0] th_reg, th_next;
    logic [31:0] id_reg, id_next;
    out_item_t   pend_reg, pend_next, out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] mul_a, mul_b;
    logic [30:0] iv;
    logic [63:0] sq_bit, sq_trial;
    logic [32:0] a_sum;
    logic signed [34:0] num;
    logic        div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_quot;
    logic [31:0] div_divisor, div_rem;
    logic [63:0] tq, tsum;
    logic        slot_free;

    trs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign iv        = (cfg.interval == '0) ? 31'd1 : cfg.interval;
    assign slot_free = !out_valid_reg || out_ready;

    // rounded interpolation of one coordinate
    function automatic logic [31:0] interp(input logic [31:0] base, input logic [48:0] p,
                                           input logic neg);
        logic signed [63:0] v;
        logic signed [63:0] w;
        v = neg ? -$signed({15'b0, p}) : $signed({15'b0, p});
        w = (v + 64'sd32768) >>> 16;
        return base + w[31:0];
    endfunction

    // shared multiplier, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        sum_next       = sum_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        scnt_next      = scnt_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        run_acc_next   = run_acc_reg;
        run_total_next = run_total_reg;
        run_k_next     = run_k_reg;
        run_ovf_next   = run_ovf_reg;
        ratio_next     = ratio_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        th_next        = th_reg;
        tl_next        = tl_reg;
        id_next        = id_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        sq_bit         = 64'd1 << {scnt_reg, 1'b0};
        sq_trial       = root_reg + sq_bit;
        a_sum          = acc_reg + step_reg;
        num            = $signed({2'b0, step_reg}) + $signed({4'b0, iv})
                         - $signed({2'b0, run_acc_reg});
        tq             = {th_reg, 32'b0} + {15'b0, tl_reg} + {47'b0, prod_reg[32:16]};
        tsum           = job_reg.t_neg ? ({1'b0, job_reg.prev_t} - tq)
                                       : ({1'b0, job_reg.prev_t} + tq);

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    pend_next.ratio    = '0;
                    pend_next.last     = 1'b1;
                    pend_next.overflow = 1'b0;
                    if (q_head.first)
                    begin
                        pend_next.out_x       = q_head.cur_x;
                        pend_next.out_y       = q_head.cur_y;
                        pend_next.out_z       = q_head.cur_z;
                        pend_next.out_time_ns = q_head.cur_t;
                        pend_next.kind        = KIND_FIRST;
                        state_next            = B_EMIT;
                    end
                    else if (q_head.huge)
                    begin
                        acc_next              = '0;
                        pend_next.out_x       = q_head.prev_x;
                        pend_next.out_y       = q_head.prev_y;
                        pend_next.out_z       = q_head.prev_z;
                        pend_next.out_time_ns = q_head.prev_t;
                        pend_next.kind        = KIND_GAP;
                        state_next            = B_EMIT;
                    end
                    else
                    begin
                        state_next = B_SQ_X;
                    end
                end
            end
            // sum of squares
            B_SQ_X:
            begin
                mul_a      = job_reg.mag_x;
                mul_b      = job_reg.mag_x;
                state_next = B_SQ_Y;
            end
            B_SQ_Y:
            begin
                mul_a      = job_reg.mag_y;
                mul_b      = job_reg.mag_y;
                sum_next   = prod_reg;
                state_next = B_SQ_Z;
            end
            B_SQ_Z:
            begin
                mul_a      = job_reg.mag_z;
                mul_b      = job_reg.mag_z;
                sum_next   = sum_reg + prod_reg;
                state_next = B_SQ_END;
            end
            B_SQ_END:
            begin
                srem_next  = sum_reg + prod_reg;
                root_next  = '0;
                scnt_next  = 5'd31;
                state_next = B_SQRT;
            end
            // square root, one result bit per cycle
            B_SQRT:
            begin
                if (srem_reg >= sq_trial)
                begin
                    srem_next = srem_reg - sq_trial;
                    root_next = (root_reg >> 1) + sq_bit;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                scnt_next = scnt_reg - 5'd1;
                if (scnt_reg == 5'd0)
                begin
                    state_next = B_ROUND;
                end
            end
            B_ROUND:
            begin
                step_next  = root_reg[32:0] + {32'b0, (srem_reg > root_reg)};
                state_next = B_CHECK;
            end
            // classify the step
            B_CHECK:
            begin
                if (step_reg == '0)
                begin
                    state_next = B_IDLE;
                end
                else if (step_reg > {2'b0, cfg.max_step})
                begin
                    acc_next              = '0;
                    pend_next.out_x       = job_reg.prev_x;
                    pend_next.out_y       = job_reg.prev_y;
                    pend_next.out_z       = job_reg.prev_z;
                    pend_next.out_time_ns = job_reg.prev_t;
                    pend_next.kind        = KIND_GAP;
                    state_next            = B_EMIT;
                end
                else if (a_sum > {2'b0, iv})
                begin
                    run_acc_next = a_sum;
                    div_start    = 1'b1;
                    div_dividend = {15'b0, a_sum - 33'd1};
                    div_divisor  = {1'b0, iv};
                    state_next   = B_DUE;
                end
                else
                begin
                    acc_next   = a_sum;
                    state_next = B_IDLE;
                end
            end
            // samples due and leftover distance
            B_DUE:
            begin
                if (div_done)
                begin
                    acc_next     = {1'b0, div_rem} + 33'd1;
                    run_ovf_next = div_quot > DIV_W'(MAX_RUN);
                    run_total_next = run_ovf_next ? RUN_W'(MAX_RUN) : div_quot[RUN_W-1:0];
                    run_k_next   = '0;
                    state_next   = B_RATIO;
                end
            end
            B_RATIO:
            begin
                div_start    = 1'b1;
                div_dividend = num[34] ? {16'b0, 32'(step_reg[32:1])}
                               : ({1'b0, num[30:0], 16'b0} + {16'b0, 32'(step_reg[32:1])});
                div_divisor  = step_reg[31:0];
                state_next   = B_RATIO_WAIT;
            end
            B_RATIO_WAIT:
            begin
                if (div_done)
                begin
                    ratio_next = div_quot[16:0];
                    state_next = B_MX;
                end
            end
            // products along the step
            B_MX:
            begin
                mul_a      = job_reg.mag_x;
                mul_b      = {15'b0, ratio_reg};
                state_next = B_MY;
            end
            B_MY:
            begin
                mul_a      = job_reg.mag_y;
                mul_b      = {15'b0, ratio_reg};
                px_next    = prod_reg[48:0];
                state_next = B_MZ;
            end
            B_MZ:
            begin
                mul_a      = job_reg.mag_z;
                mul_b      = {15'b0, ratio_reg};
                py_next    = prod_reg[48:0];
                state_next = B_MTH;
            end
            B_MTH:
            begin
                mul_a      = {17'b0, job_reg.dt[62:48]};
                mul_b      = {15'b0, ratio_reg};
                pz_next    = prod_reg[48:0];
                state_next = B_MTL;
            end
            B_MTL:
            begin
                mul_a      = job_reg.dt[47:16];
                mul_b      = {15'b0, ratio_reg};
                th_next    = prod_reg[31:0];
                state_next = B_MTF;
            end
            B_MTF:
            begin
                mul_a      = {16'b0, job_reg.dt[15:0]};
                mul_b      = {15'b0, ratio_reg};
                tl_next    = prod_reg[48:0];
                state_next = B_FORM;
            end
            B_FORM:
            begin
                pend_next.out_x       = interp(job_reg.prev_x, px_reg, job_reg.neg_x);
                pend_next.out_y       = interp(job_reg.prev_y, py_reg, job_reg.neg_y);
                pend_next.out_z       = interp(job_reg.prev_z, pz_reg, job_reg.neg_z);
                pend_next.out_time_ns = tsum[62:0];
                pend_next.kind        = KIND_INTERP;
                pend_next.ratio       = ratio_reg;
                pend_next.last        = run_k_reg == run_total_reg - RUN_W'(1);
                pend_next.overflow    = pend_next.last && run_ovf_reg;
                state_next            = B_EMIT;
            end
            // hand the word to the output register
            B_EMIT:
            begin
                if (slot_free)
                begin
                    out_next           = pend_reg;
                    out_next.sample_id = id_reg;
                    out_valid_next     = 1'b1;
                    id_next            = id_reg + 32'd1;
                    if (pend_reg.last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        run_acc_next = run_acc_reg - {2'b0, iv};
                        run_k_next   = run_k_reg + RUN_W'(1);
                        state_next   = B_RATIO;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            acc_reg       <= '0;
            id_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            id_reg        <= id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        sum_reg       <= sum_next;
        srem_reg      <= srem_next;
        root_reg      <= root_next;
        scnt_reg      <= scnt_next;
        step_reg      <= step_next;
        run_acc_reg   <= run_acc_next;
        run_total_reg <= run_total_next;
        run_k_reg     <= run_k_next;
        run_ovf_reg   <= run_ovf_next;
        ratio_reg     <= ratio_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pz_reg        <= pz_next;
        th_reg        <= th_next;
        tl_reg        <= tl_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

endmodule

`default_nettype wire

@@ rtl/trajectory_distance_resampler_core.sv @@
// trajectory_distance_resampler_core: top level, configuration registers and wiring
// depends on trs_pkg, trs_front, trs_queue, trs_back
`timescale 1ns / 1ps
`default_nettype none

// Resamples a pose stream at fixed travelled distance.
// in_valid/in_ready carry one pose word (Q16.16 position, ns time); out_valid/
// out_ready carry result words. One input gives zero to 64 results; last marks
// the final one. The front takes a pose every cycle while its two-entry queue
// has room, so up to two poses wait while the back works.
// Per pose the back end takes it from the queue, sums the squares, takes the
// square root (one result bit per cycle), rounds it and checks the step. A
// run then divides for the due count and, per result, divides for the ratio,
// forms the products and the result and hands it off; the back end takes no
// new pose until the run is done. The 48-step shared divider dominates.
// A first pose or a huge jump skips the squares and root; a gap found after
// the root or a step below one interval ends after the check. Results land in
// one output register; while the receiver holds out_ready low the back end
// waits and the queue then fills and drops in_ready.
// Reset clears the previous pose, accumulator, id counter and the queue and loads
// sample_interval 65536 and max_step 655360. cfg_wr_en writes register cfg_index
// (0 interval, 1 max step), only while idle: a user rule, not enforced.
module trajectory_distance_resampler_core
    import trs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_full, q_push, q_pop, q_not_empty;
    job_t q_job, q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval <= INTERVAL_RST;
            cfg_reg.max_step <= MAX_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INTERVAL: cfg_reg.interval <= cfg_data;
                CFG_MAX_STEP: cfg_reg.max_step <= cfg_data;
                default:      cfg_reg.interval <= cfg_data;
            endcase
        end
    end

    trs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    trs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    trs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire
